### hdl/cst_pkg.sv
package cst_pkg;

   localparam int MAX_DEPTH   = 255;
   localparam int QUEUE_DEPTH = 4;

   localparam int KIND_W = 5;
   localparam int CHAR_W = 8;

   localparam logic [KIND_W-1:0] K_INT    = 5'd0;
   localparam logic [KIND_W-1:0] K_FLOAT  = 5'd1;
   localparam logic [KIND_W-1:0] K_IDENT  = 5'd2;
   localparam logic [KIND_W-1:0] K_STRING = 5'd3;
   localparam logic [KIND_W-1:0] K_LPAREN = 5'd4;
   localparam logic [KIND_W-1:0] K_RPAREN = 5'd5;
   localparam logic [KIND_W-1:0] K_PLUS   = 5'd6;
   localparam logic [KIND_W-1:0] K_MINUS  = 5'd7;
   localparam logic [KIND_W-1:0] K_STAR   = 5'd8;
   localparam logic [KIND_W-1:0] K_SLASH  = 5'd9;
   localparam logic [KIND_W-1:0] K_PCT    = 5'd10;
   localparam logic [KIND_W-1:0] K_EQ     = 5'd11;
   localparam logic [KIND_W-1:0] K_COMMA  = 5'd12;
   localparam logic [KIND_W-1:0] K_EOS    = 5'd13;
   localparam logic [KIND_W-1:0] K_TRU    = 5'd14;
   localparam logic [KIND_W-1:0] K_FLS    = 5'd15;
   localparam logic [KIND_W-1:0] K_WHN    = 5'd16;
   localparam logic [KIND_W-1:0] K_IS     = 5'd17;
   localparam logic [KIND_W-1:0] K_NOT    = 5'd18;
   localparam logic [KIND_W-1:0] K_DO     = 5'd19;
   localparam logic [KIND_W-1:0] K_END    = 5'd20;
   localparam logic [KIND_W-1:0] K_LINE   = 5'd21;

   // One accepted character expands into these slots, emitted in this order:
   // end, up to three buffered ident chars, one char, end, end, line done.
   typedef struct packed {
      logic                         e0_v;
      logic [KIND_W-1:0]            e0_kind;
      logic [1:0]                   t_n;
      logic [2:0][CHAR_W-1:0]       t_buf;
      logic                         c_v;
      logic [KIND_W-1:0]            c_kind;
      logic [CHAR_W-1:0]            c_char;
      logic                         e1_v;
      logic [KIND_W-1:0]            e1_kind;
      logic                         e2_v;
      logic [KIND_W-1:0]            e2_kind;
      logic                         l_v;
      logic                         l_unb;
   } cmd_type;

endpackage

### hdl/cst_front.sv
module cst_front #(
   parameter int MAX_DEPTH = cst_pkg::MAX_DEPTH
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [cst_pkg::CHAR_W-1:0]   req_char_in,
   input  logic                         req_line_end,
   input  logic                         q_full,
   output logic                         q_push,
   output cst_pkg::cmd_type             q_data
);

   localparam int DEPTH_W = $clog2(MAX_DEPTH + 1);

   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_NL    = 8'h0A;

   typedef struct packed {
      logic                                in_str;
      logic [DEPTH_W-1:0]                  depth;
      logic                                ovf;
      logic                                num_a;
      logic                                num_dot;
      logic                                id_a;
      logic [2:0]                          id_cnt;
      logic [2:0][cst_pkg::CHAR_W-1:0]     id_buf;
      cst_pkg::cmd_type                    cmd;
   } fe_type;

   logic                                in_str_ff,  in_str_in;
   logic [DEPTH_W-1:0]                  depth_ff,   depth_in;
   logic                                ovf_ff,     ovf_in;
   logic                                num_a_ff,   num_a_in;
   logic                                num_dot_ff, num_dot_in;
   logic                                id_a_ff,    id_a_in;
   logic [2:0]                          id_cnt_ff,  id_cnt_in;
   logic [2:0][cst_pkg::CHAR_W-1:0]     id_buf_ff,  id_buf_in;
   logic                                accept;
   cst_pkg::cmd_type                    cmd;

   function automatic logic [cst_pkg::KIND_W-1:0] kw_kind(
      input logic [2:0][cst_pkg::CHAR_W-1:0] b, input logic [2:0] n);
      logic [cst_pkg::KIND_W-1:0] k;
      k = cst_pkg::K_IDENT;
      if (n == 3'd3) begin
         if ({b[0], b[1], b[2]} == "tru") k = cst_pkg::K_TRU;
         else if ({b[0], b[1], b[2]} == "fls") k = cst_pkg::K_FLS;
         else if ({b[0], b[1], b[2]} == "whn") k = cst_pkg::K_WHN;
         else if ({b[0], b[1], b[2]} == "not") k = cst_pkg::K_NOT;
         else if ({b[0], b[1], b[2]} == "end") k = cst_pkg::K_END;
      end else if (n == 3'd2) begin
         if ({b[0], b[1]} == "is") k = cst_pkg::K_IS;
         else if ({b[0], b[1]} == "do") k = cst_pkg::K_DO;
      end
      return k;
   endfunction

   // {valid, kind}
   function automatic logic [cst_pkg::KIND_W:0] op_lookup(input logic [7:0] c);
      logic [cst_pkg::KIND_W:0] r;
      case (c)
         "(":     r = {1'b1, cst_pkg::K_LPAREN};
         ")":     r = {1'b1, cst_pkg::K_RPAREN};
         "+":     r = {1'b1, cst_pkg::K_PLUS};
         "-":     r = {1'b1, cst_pkg::K_MINUS};
         "*":     r = {1'b1, cst_pkg::K_STAR};
         "/":     r = {1'b1, cst_pkg::K_SLASH};
         "%":     r = {1'b1, cst_pkg::K_PCT};
         "=":     r = {1'b1, cst_pkg::K_EQ};
         ",":     r = {1'b1, cst_pkg::K_COMMA};
         CH_NL:   r = {1'b1, cst_pkg::K_EOS};
         default: r = '0;
      endcase
      return r;
   endfunction

   function automatic fe_type put_end(input fe_type s, input logic [cst_pkg::KIND_W-1:0] k);
      fe_type r;
      r = s;
      if (r.cmd.t_n != 2'd0 || r.cmd.c_v || r.cmd.e0_v) begin
         if (!r.cmd.e1_v) begin
            r.cmd.e1_v    = 1'b1;
            r.cmd.e1_kind = k;
         end else begin
            r.cmd.e2_v    = 1'b1;
            r.cmd.e2_kind = k;
         end
      end else begin
         r.cmd.e0_v    = 1'b1;
         r.cmd.e0_kind = k;
      end
      return r;
   endfunction

   function automatic fe_type put_char(input fe_type s, input logic [cst_pkg::KIND_W-1:0] k,
                                       input logic [7:0] ch);
      fe_type r;
      r = s;
      r.cmd.c_v    = 1'b1;
      r.cmd.c_kind = k;
      r.cmd.c_char = ch;
      return r;
   endfunction

   function automatic fe_type close_ident(input fe_type s);
      fe_type r;
      logic [cst_pkg::KIND_W-1:0] k;
      r = s;
      k = kw_kind(r.id_buf, r.id_cnt);
      if (k == cst_pkg::K_IDENT && r.id_cnt <= 3'd3) begin
         r.cmd.t_n   = r.id_cnt[1:0];
         r.cmd.t_buf = r.id_buf;
      end
      r = put_end(r, k);
      r.id_a   = 1'b0;
      r.id_cnt = 3'd0;
      return r;
   endfunction

   function automatic fe_type ident_add(input fe_type s, input logic [7:0] ch);
      fe_type r;
      r = s;
      if (r.id_cnt < 3'd3) begin
         r.id_buf[r.id_cnt[1:0]] = ch;
         r.id_cnt = r.id_cnt + 3'd1;
      end else if (r.id_cnt == 3'd3) begin
         r.cmd.t_n   = 2'd3;
         r.cmd.t_buf = r.id_buf;
         r = put_char(r, cst_pkg::K_IDENT, ch);
         r.id_cnt = 3'd4;
      end else begin
         r = put_char(r, cst_pkg::K_IDENT, ch);
      end
      return r;
   endfunction

   always_comb begin
      fe_type                     s;
      logic                       cons;
      logic                       unb;
      logic                       is_sp;
      logic                       is_num;
      logic [cst_pkg::KIND_W:0]   op;
      s.in_str  = in_str_ff;
      s.depth   = depth_ff;
      s.ovf     = ovf_ff;
      s.num_a   = num_a_ff;
      s.num_dot = num_dot_ff;
      s.id_a    = id_a_ff;
      s.id_cnt  = id_cnt_ff;
      s.id_buf  = id_buf_ff;
      s.cmd     = '0;
      cons      = 1'b0;
      unb       = 1'b0;
      is_sp     = (req_char_in == CH_SPACE) || (req_char_in == CH_TAB) || (req_char_in == CH_CR);
      is_num    = (req_char_in >= "0" && req_char_in <= "9") || (req_char_in == CH_DOT);
      op        = op_lookup(req_char_in);

      if (s.in_str) begin
         if (req_char_in == CH_QUOTE) begin
            s = put_end(s, cst_pkg::K_STRING);
            s.in_str = 1'b0;
         end else begin
            s = put_char(s, cst_pkg::K_STRING, req_char_in);
         end
         cons = 1'b1;
      end

      if (!cons && s.num_a) begin
         if (is_num) begin
            if (req_char_in == CH_DOT) s.num_dot = 1'b1;
            s = put_char(s, cst_pkg::K_INT, req_char_in);
            cons = 1'b1;
         end else begin
            s = put_end(s, s.num_dot ? cst_pkg::K_FLOAT : cst_pkg::K_INT);
            s.num_a   = 1'b0;
            s.num_dot = 1'b0;
         end
      end

      if (!cons && s.id_a) begin
         if (op[cst_pkg::KIND_W] || is_sp || req_char_in == CH_QUOTE) begin
            s = close_ident(s);
         end else begin
            s = ident_add(s, req_char_in);
            cons = 1'b1;
         end
      end

      if (!cons) begin
         if (req_char_in == CH_QUOTE) begin
            s.in_str = 1'b1;
         end else if (is_sp) begin
            s.in_str = s.in_str;
         end else if (is_num) begin
            s.num_a   = 1'b1;
            s.num_dot = (req_char_in == CH_DOT);
            s = put_char(s, cst_pkg::K_INT, req_char_in);
         end else if (op[cst_pkg::KIND_W]) begin
            if (op[cst_pkg::KIND_W-1:0] == cst_pkg::K_LPAREN) begin
               if (s.depth == DEPTH_W'(MAX_DEPTH)) s.ovf = 1'b1;
               else s.depth = s.depth + DEPTH_W'(1);
            end else if (op[cst_pkg::KIND_W-1:0] == cst_pkg::K_RPAREN) begin
               if (s.depth != '0) s.depth = s.depth - DEPTH_W'(1);
            end
            s = put_end(s, op[cst_pkg::KIND_W-1:0]);
         end else begin
            s.id_a   = 1'b1;
            s.id_cnt = 3'd0;
            s = ident_add(s, req_char_in);
         end
      end

      if (req_line_end) begin
         unb = s.in_str || (s.depth != '0) || s.ovf;
         if (s.num_a) s = put_end(s, s.num_dot ? cst_pkg::K_FLOAT : cst_pkg::K_INT);
         if (s.id_a) s = close_ident(s);
         if (s.in_str) s = put_end(s, cst_pkg::K_STRING);
         s.cmd.l_v   = 1'b1;
         s.cmd.l_unb = unb;
         s.in_str  = 1'b0;
         s.depth   = '0;
         s.ovf     = 1'b0;
         s.num_a   = 1'b0;
         s.num_dot = 1'b0;
         s.id_a    = 1'b0;
         s.id_cnt  = 3'd0;
      end

      in_str_in  = s.in_str;
      depth_in   = s.depth;
      ovf_in     = s.ovf;
      num_a_in   = s.num_a;
      num_dot_in = s.num_dot;
      id_a_in    = s.id_a;
      id_cnt_in  = s.id_cnt;
      id_buf_in  = s.id_buf;
      cmd        = s.cmd;
   end

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;
   assign q_data    = cmd;
   assign q_push    = accept && (cmd.e0_v || (cmd.t_n != 2'd0) || cmd.c_v ||
                                 cmd.e1_v || cmd.e2_v || cmd.l_v);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_str_ff  <= 1'b0;
         depth_ff   <= '0;
         ovf_ff     <= 1'b0;
         num_a_ff   <= 1'b0;
         num_dot_ff <= 1'b0;
         id_a_ff    <= 1'b0;
         id_cnt_ff  <= 3'd0;
      end else if (accept) begin
         in_str_ff  <= in_str_in;
         depth_ff   <= depth_in;
         ovf_ff     <= ovf_in;
         num_a_ff   <= num_a_in;
         num_dot_ff <= num_dot_in;
         id_a_ff    <= id_a_in;
         id_cnt_ff  <= id_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         id_buf_ff <= id_buf_in;
      end
   end

endmodule

### hdl/cst_queue.sv
module cst_queue #(
   parameter int DEPTH = cst_pkg::QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  cst_pkg::cmd_type   push_data,
   output logic               full,
   input  logic               pop,
   output cst_pkg::cmd_type   head,
   output logic               empty
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   cst_pkg::cmd_type   mem [DEPTH];
   logic [AW-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [AW:0]        cnt_ff,    cnt_in;

   assign full  = (cnt_ff == (AW+1)'(DEPTH));
   assign empty = (cnt_ff == '0);
   assign head  = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (push && !pop) cnt_in = cnt_ff + (AW+1)'(1);
      else if (pop && !push) cnt_in = cnt_ff - (AW+1)'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### hdl/cst_back.sv
module cst_back (
   input  logic                         clock,
   input  logic                         reset,
   input  cst_pkg::cmd_type             q_head,
   input  logic                         q_empty,
   output logic                         q_pop,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [cst_pkg::KIND_W-1:0]   rsp_kind,
   output logic                         rsp_has_char,
   output logic [cst_pkg::CHAR_W-1:0]   rsp_text_char,
   output logic                         rsp_token_last,
   output logic                         rsp_line_last,
   output logic                         rsp_unbalanced
);

   localparam logic [2:0] SL_E0 = 3'd0;
   localparam logic [2:0] SL_T0 = 3'd1;
   localparam logic [2:0] SL_T1 = 3'd2;
   localparam logic [2:0] SL_T2 = 3'd3;
   localparam logic [2:0] SL_C  = 3'd4;
   localparam logic [2:0] SL_E1 = 3'd5;
   localparam logic [2:0] SL_E2 = 3'd6;
   localparam logic [2:0] SL_L  = 3'd7;

   logic [2:0]                    step_ff, step_in;
   logic                          valid_ff, valid_in;
   logic [cst_pkg::KIND_W-1:0]    kind_ff, kind_in;
   logic                          has_ff, has_in;
   logic [cst_pkg::CHAR_W-1:0]    char_ff, char_in;
   logic                          tlast_ff, tlast_in;
   logic                          llast_ff, llast_in;
   logic                          unb_ff, unb_in;
   logic [7:0]                    slots;
   logic [7:0]                    masked;
   logic [7:0]                    rest;
   logic [2:0]                    sel;
   logic                          last;
   logic                          go;

   always_comb begin
      slots[SL_E0] = q_head.e0_v;
      slots[SL_T0] = (q_head.t_n != 2'd0);
      slots[SL_T1] = (q_head.t_n >= 2'd2);
      slots[SL_T2] = (q_head.t_n == 2'd3);
      slots[SL_C]  = q_head.c_v;
      slots[SL_E1] = q_head.e1_v;
      slots[SL_E2] = q_head.e2_v;
      slots[SL_L]  = q_head.l_v;
      masked = slots & (8'hFF << step_ff);
      sel = SL_L;
      for (int i = 7; i >= 0; i--) begin
         if (masked[i]) sel = 3'(i);
      end
      rest = masked & ~(8'd1 << sel);
      last = (rest == 8'd0);
   end

   assign go    = !q_empty && (!valid_ff || rsp_ready);
   assign q_pop = go && last;

   always_comb begin
      step_in  = step_ff;
      valid_in = valid_ff && !rsp_ready;
      kind_in  = kind_ff;
      has_in   = has_ff;
      char_in  = char_ff;
      tlast_in = tlast_ff;
      llast_in = llast_ff;
      unb_in   = unb_ff;
      if (go) begin
         step_in  = last ? 3'd0 : sel + 3'd1;
         valid_in = 1'b1;
         has_in   = 1'b0;
         char_in  = '0;
         tlast_in = 1'b0;
         llast_in = 1'b0;
         unb_in   = 1'b0;
         case (sel)
            SL_E0: begin
               kind_in  = q_head.e0_kind;
               tlast_in = 1'b1;
            end
            SL_T0: begin
               kind_in = cst_pkg::K_IDENT;
               has_in  = 1'b1;
               char_in = q_head.t_buf[0];
            end
            SL_T1: begin
               kind_in = cst_pkg::K_IDENT;
               has_in  = 1'b1;
               char_in = q_head.t_buf[1];
            end
            SL_T2: begin
               kind_in = cst_pkg::K_IDENT;
               has_in  = 1'b1;
               char_in = q_head.t_buf[2];
            end
            SL_C: begin
               kind_in = q_head.c_kind;
               has_in  = 1'b1;
               char_in = q_head.c_char;
            end
            SL_E1: begin
               kind_in  = q_head.e1_kind;
               tlast_in = 1'b1;
            end
            SL_E2: begin
               kind_in  = q_head.e2_kind;
               tlast_in = 1'b1;
            end
            default: begin
               kind_in  = cst_pkg::K_LINE;
               llast_in = 1'b1;
               unb_in   = q_head.l_unb;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= 3'd0;
         valid_ff <= 1'b0;
      end else begin
         step_ff  <= step_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff  <= kind_in;
      has_ff   <= has_in;
      char_ff  <= char_in;
      tlast_ff <= tlast_in;
      llast_ff <= llast_in;
      unb_ff   <= unb_in;
   end

   assign rsp_valid      = valid_ff;
   assign rsp_kind       = kind_ff;
   assign rsp_has_char   = has_ff;
   assign rsp_text_char  = char_ff;
   assign rsp_token_last = tlast_ff;
   assign rsp_line_last  = llast_ff;
   assign rsp_unbalanced = unb_ff;

endmodule

### hdl/char_stream_tokenizer.sv
// Character stream tokenizer.
// req channel: one source byte per beat (req_char_in) with req_line_end on
// the last byte of a line. rsp channel: token results; character beats carry
// text (rsp_has_char), end beats carry the token kind (rsp_token_last), and
// every line closes with a line-done beat (rsp_line_last, rsp_unbalanced).
// The front classifies a byte and updates tokenizer state in the cycle it is
// accepted, writing a compact result list into a 4-entry queue. The back
// pops the queue and emits one result beat per cycle unless the receiver stalls.
// Throughput: one byte per cycle, with no stall, while each byte yields at
// most one result; a byte yielding more (a byte yields 0 to 6) holds the back
// until all are out, and the queue absorbs such bursts before req_ready
// drops. Results pass through the queue, then the back's output register.
// Reset clears tokenizer state except id_buf, empties the queue; no cleanup pass.
// When the receiver stalls, the output register holds its beat, the queue
// fills, and req_ready falls once the queue is full.
module char_stream_tokenizer #(
   parameter int MAX_DEPTH   = cst_pkg::MAX_DEPTH,
   parameter int QUEUE_DEPTH = cst_pkg::QUEUE_DEPTH
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [cst_pkg::CHAR_W-1:0]   req_char_in,
   input  logic                         req_line_end,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [cst_pkg::KIND_W-1:0]   rsp_kind,
   output logic                         rsp_has_char,
   output logic [cst_pkg::CHAR_W-1:0]   rsp_text_char,
   output logic                         rsp_token_last,
   output logic                         rsp_line_last,
   output logic                         rsp_unbalanced
);

   logic               q_full;
   logic               q_push;
   logic               q_pop;
   logic               q_empty;
   cst_pkg::cmd_type   q_data;
   cst_pkg::cmd_type   q_head;

   cst_front #(
      .MAX_DEPTH (MAX_DEPTH)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_char_in  (req_char_in),
      .req_line_end (req_line_end),
      .q_full       (q_full),
      .q_push       (q_push),
      .q_data       (q_data)
   );

   cst_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_data),
      .full      (q_full),
      .pop       (q_pop),
      .head      (q_head),
      .empty     (q_empty)
   );

   cst_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_head         (q_head),
      .q_empty        (q_empty),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_kind       (rsp_kind),
      .rsp_has_char   (rsp_has_char),
      .rsp_text_char  (rsp_text_char),
      .rsp_token_last (rsp_token_last),
      .rsp_line_last  (rsp_line_last),
      .rsp_unbalanced (rsp_unbalanced)
   );

   // a line-end beat always leaves work in the queue for the back
   a_line_end_queued: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_line_end) |=> !q_empty)
      else $error("line end beat did not reach the queue");

   a_unb_on_line_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_unbalanced) |-> (rsp_line_last && !rsp_has_char))
      else $error("unbalanced flag outside line done beat");

   a_char_kind: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_has_char) |->
         ((rsp_kind == cst_pkg::K_INT) || (rsp_kind == cst_pkg::K_IDENT) ||
          (rsp_kind == cst_pkg::K_STRING)) && !rsp_token_last && !rsp_line_last)
      else $error("text beat with bad kind or flags");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      q_full |-> !q_push)
      else $error("push into full queue");

endmodule

### sim/char_stream_tokenizer_tb.sv
`timescale 1ns / 1ps

module char_stream_tokenizer_tb;

   localparam int LONG_HOLD = 200;

   typedef struct packed {
      logic [cst_pkg::KIND_W-1:0] kind;
      logic                       has_char;
      logic [cst_pkg::CHAR_W-1:0] text_char;
      logic                       token_last;
      logic                       line_last;
      logic                       unbalanced;
   } tok_result_type;

   class token_scoreboard;
      tok_result_type pending_tokens[$];
      int             errors;
      bit             in_str;
      int             depth;
      bit             ovf;
      bit             num_on;
      bit             num_dot;
      bit             id_on;
      byte unsigned   id_buf[3];
      int             id_cnt;

      function new();
         errors = 0;
         clear_state();
      endfunction

      function void clear_state();
         in_str  = 0;
         depth   = 0;
         ovf     = 0;
         num_on  = 0;
         num_dot = 0;
         id_on   = 0;
         id_cnt  = 0;
         foreach (id_buf[i]) id_buf[i] = 0;
      endfunction

      function int pending();
         return pending_tokens.size();
      endfunction

      function void queue_token(logic [cst_pkg::KIND_W-1:0] k, bit has, byte unsigned ch,
                                bit tl, bit ll, bit unb);
         tok_result_type r;
         r.kind       = k;
         r.has_char   = has;
         r.text_char  = has ? ch : 8'h00;
         r.token_last = tl;
         r.line_last  = ll;
         r.unbalanced = unb;
         pending_tokens.push_back(r);
      endfunction

      function bit is_blank(byte unsigned c);
         return c == " " || c == "\t" || c == "\r";
      endfunction

      function bit is_num_char(byte unsigned c);
         return (c >= "0" && c <= "9") || c == ".";
      endfunction

      function bit op_lookup(input byte unsigned c, output logic [cst_pkg::KIND_W-1:0] k);
         op_lookup = 1;
         k = cst_pkg::K_IDENT;
         case (c)
            "(":  k = cst_pkg::K_LPAREN;
            ")":  k = cst_pkg::K_RPAREN;
            "+":  k = cst_pkg::K_PLUS;
            "-":  k = cst_pkg::K_MINUS;
            "*":  k = cst_pkg::K_STAR;
            "/":  k = cst_pkg::K_SLASH;
            "%":  k = cst_pkg::K_PCT;
            "=":  k = cst_pkg::K_EQ;
            ",":  k = cst_pkg::K_COMMA;
            "\n": k = cst_pkg::K_EOS;
            default: op_lookup = 0;
         endcase
      endfunction

      function logic [cst_pkg::KIND_W-1:0] ident_kind();
         ident_kind = cst_pkg::K_IDENT;
         if (id_cnt == 3) begin
            case ({id_buf[0], id_buf[1], id_buf[2]})
               "tru": ident_kind = cst_pkg::K_TRU;
               "fls": ident_kind = cst_pkg::K_FLS;
               "whn": ident_kind = cst_pkg::K_WHN;
               "not": ident_kind = cst_pkg::K_NOT;
               "end": ident_kind = cst_pkg::K_END;
               default: ident_kind = cst_pkg::K_IDENT;
            endcase
         end else if (id_cnt == 2) begin
            case ({id_buf[0], id_buf[1]})
               "is": ident_kind = cst_pkg::K_IS;
               "do": ident_kind = cst_pkg::K_DO;
               default: ident_kind = cst_pkg::K_IDENT;
            endcase
         end
      endfunction

      function void close_number();
         queue_token(num_dot ? cst_pkg::K_FLOAT : cst_pkg::K_INT, 0, 0, 1, 0, 0);
         num_on  = 0;
         num_dot = 0;
      endfunction

      function void close_ident();
         logic [cst_pkg::KIND_W-1:0] k;
         k = ident_kind();
         if (k == cst_pkg::K_IDENT && id_cnt <= 3)
            for (int i = 0; i < id_cnt; i++)
               queue_token(cst_pkg::K_IDENT, 1, id_buf[i], 0, 0, 0);
         queue_token(k, 0, 0, 1, 0, 0);
         id_on  = 0;
         id_cnt = 0;
      endfunction

      // past three chars the buffer is flushed and text streams directly
      function void ident_add(byte unsigned c);
         if (id_cnt < 3) begin
            id_buf[id_cnt] = c;
            id_cnt++;
         end else if (id_cnt == 3) begin
            for (int i = 0; i < 3; i++) queue_token(cst_pkg::K_IDENT, 1, id_buf[i], 0, 0, 0);
            queue_token(cst_pkg::K_IDENT, 1, c, 0, 0, 0);
            id_cnt = 4;
         end else begin
            queue_token(cst_pkg::K_IDENT, 1, c, 0, 0, 0);
         end
      endfunction

      function void note_char(byte unsigned c, bit le);
         logic [cst_pkg::KIND_W-1:0] op_k;
         bit                         is_op;
         bit                         taken;
         bit                         unb;
         taken = 0;
         is_op = op_lookup(c, op_k);
         if (in_str) begin
            if (c == "\"") begin
               queue_token(cst_pkg::K_STRING, 0, 0, 1, 0, 0);
               in_str = 0;
            end else begin
               queue_token(cst_pkg::K_STRING, 1, c, 0, 0, 0);
            end
            taken = 1;
         end
         if (!taken && num_on) begin
            if (is_num_char(c)) begin
               if (c == ".") num_dot = 1;
               queue_token(cst_pkg::K_INT, 1, c, 0, 0, 0);
               taken = 1;
            end else begin
               close_number();
            end
         end
         if (!taken && id_on) begin
            if (is_op || is_blank(c) || c == "\"") begin
               close_ident();
            end else begin
               ident_add(c);
               taken = 1;
            end
         end
         if (!taken) begin
            if (c == "\"") begin
               in_str = 1;
            end else if (is_blank(c)) begin
               // skipped
            end else if (is_num_char(c)) begin
               num_on  = 1;
               num_dot = (c == ".");
               queue_token(cst_pkg::K_INT, 1, c, 0, 0, 0);
            end else if (is_op) begin
               if (c == "(") begin
                  if (depth >= cst_pkg::MAX_DEPTH) ovf = 1;
                  else depth++;
               end else if (c == ")" && depth > 0) begin
                  depth--;
               end
               queue_token(op_k, 0, 0, 1, 0, 0);
            end else begin
               id_on  = 1;
               id_cnt = 0;
               ident_add(c);
            end
         end
         if (le) begin
            unb = in_str || depth != 0 || ovf;
            if (num_on) close_number();
            if (id_on) close_ident();
            if (in_str) queue_token(cst_pkg::K_STRING, 0, 0, 1, 0, 0);
            queue_token(cst_pkg::K_LINE, 0, 0, 0, 1, unb);
            clear_state();
         end
      endfunction

      function string fmt(tok_result_type r);
         return $sformatf("kind=%0d has=%0b char=%02h tlast=%0b llast=%0b unb=%0b",
                          r.kind, r.has_char, r.text_char, r.token_last, r.line_last,
                          r.unbalanced);
      endfunction

      function void check_token_beat(tok_result_type got);
         tok_result_type want;
         if (pending_tokens.size() == 0) begin
            errors++;
            if (errors <= 10) $display("rsp beat with nothing pending: %s", fmt(got));
            return;
         end
         want = pending_tokens.pop_front();
         if (got.kind !== want.kind || got.has_char !== want.has_char ||
             got.text_char !== want.text_char || got.token_last !== want.token_last ||
             got.line_last !== want.line_last || got.unbalanced !== want.unbalanced) begin
            errors++;
            if (errors <= 10)
               $display("rsp mismatch: expected %s, got %s", fmt(want), fmt(got));
         end
      endfunction
   endclass

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_ready;
   logic [cst_pkg::CHAR_W-1:0] req_char_in;
   logic                       req_line_end;
   logic                       rsp_valid;
   logic                       rsp_ready;
   logic [cst_pkg::KIND_W-1:0] rsp_kind;
   logic                       rsp_has_char;
   logic [cst_pkg::CHAR_W-1:0] rsp_text_char;
   logic                       rsp_token_last;
   logic                       rsp_line_last;
   logic                       rsp_unbalanced;

   token_scoreboard sb;
   int              beats_sent = 0;
   bit              sender_gaps = 0;
   bit              gaps_now = 0;
   bit              quiet = 0;
   bit              hold_request = 0;
   byte unsigned    line_bytes[$];
   string           keywords[7] = '{"tru", "fls", "whn", "is", "not", "do", "end"};
   string           op_set = "()+-*/%=,\n";

   char_stream_tokenizer dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_char_in    (req_char_in),
      .req_line_end   (req_line_end),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_kind       (rsp_kind),
      .rsp_has_char   (rsp_has_char),
      .rsp_text_char  (rsp_text_char),
      .rsp_token_last (rsp_token_last),
      .rsp_line_last  (rsp_line_last),
      .rsp_unbalanced (rsp_unbalanced)
   );

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("TB_ERROR");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_token_beat({rsp_kind, rsp_has_char, rsp_text_char, rsp_token_last,
                              rsp_line_last, rsp_unbalanced});
   end

   // receiver: random stalls, one long hold on request, always ready when quiet
   initial begin
      rsp_ready <= 0;
      forever begin
         if (hold_request) begin
            rsp_ready <= 0;
            repeat (LONG_HOLD) @(posedge clock);
            hold_request = 0;
         end else if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 0;
            repeat ($urandom_range(1, 15)) @(posedge clock);
         end else begin
            rsp_ready <= 1;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end
      end
   end

   task automatic send_beat(input byte unsigned c, input bit le);
      if (gaps_now && !quiet && $urandom_range(0, 4) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_valid    <= 1;
      req_char_in  <= c;
      req_line_end <= le;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_char(c, le);
      if (le || !(c == " " || c == "\t" || c == "\r")) beats_sent++;
   endtask

   task automatic send_text(input string s, input bit le_at_end);
      for (int i = 0; i < s.len(); i++) send_beat(s[i], le_at_end && i == s.len() - 1);
   endtask

   task automatic wait_drained();
      req_valid <= 0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   function automatic void add_word(string w);
      for (int i = 0; i < w.len(); i++) line_bytes.push_back(w[i]);
   endfunction

   function automatic byte unsigned rand_letter();
      return 8'("a") + 8'($urandom_range(0, 25));
   endfunction

   function automatic void add_token();
      int n;
      byte unsigned b;
      case ($urandom_range(0, 9))
         0, 1: add_word(keywords[$urandom_range(0, 6)]);
         2: begin
            n = $urandom_range(1, 3);
            repeat (n) line_bytes.push_back(rand_letter());
         end
         3: begin
            if ($urandom_range(0, 1)) add_word(keywords[$urandom_range(0, 6)]);
            else line_bytes.push_back(rand_letter());
            n = $urandom_range(1, 4);
            repeat (n) line_bytes.push_back(rand_letter());
         end
         4: begin
            n = $urandom_range(1, 5);
            repeat (n) line_bytes.push_back(8'("0") + 8'($urandom_range(0, 9)));
         end
         5: begin
            n = $urandom_range(2, 5);
            repeat (n) begin
               if ($urandom_range(0, 2) == 0) line_bytes.push_back(".");
               else line_bytes.push_back(8'("0") + 8'($urandom_range(0, 9)));
            end
         end
         6: begin
            line_bytes.push_back("\"");
            n = $urandom_range(0, 5);
            repeat (n) begin
               b = 8'($urandom_range(0, 255));
               if (b == "\"") b = "'";
               line_bytes.push_back(b);
            end
            if ($urandom_range(0, 7) != 0) line_bytes.push_back("\"");
         end
         7: line_bytes.push_back(op_set[$urandom_range(0, 9)]);
         8: add_word($urandom_range(0, 2) == 0 ? "\t" : ($urandom_range(0, 1) ? " " : "\r"));
         default: line_bytes.push_back(8'($urandom_range(0, 255)));
      endcase
      if ($urandom_range(0, 3) != 0) begin
         if ($urandom_range(0, 1)) line_bytes.push_back(" ");
         else line_bytes.push_back(op_set[$urandom_range(0, 9)]);
      end
   endfunction

   task automatic send_random_line();
      int n;
      line_bytes.delete();
      if ($urandom_range(0, 5) == 0) begin
         n = $urandom_range(1, 10);
         repeat (n) line_bytes.push_back(8'($urandom_range(0, 255)));
      end else begin
         n = $urandom_range(1, 6);
         repeat (n) add_token();
      end
      gaps_now = sender_gaps && $urandom_range(0, 2) != 0;
      for (int i = 0; i < line_bytes.size(); i++)
         send_beat(line_bytes[i], i == line_bytes.size() - 1);
   endtask

   task automatic random_lines(input int n);
      int target;
      target = beats_sent + n;
      while (beats_sent < target) send_random_line();
   endtask

   initial begin
      int guard;
      sb = new();
      reset        <= 1;
      req_valid    <= 0;
      req_char_in  <= 0;
      req_line_end <= 0;
      repeat (2) @(posedge clock);
      reset <= 0;

      // stray close paren, all operators, quote ending an ident, open string,
      // NUL and 0xFF as ident chars, float, two-char keyword
      send_text(")", 1);
      send_text("(+-*/%=,\n", 1);
      send_text("is\"ab", 1);
      send_beat(8'h00, 0);
      send_beat(8'hFF, 0);
      send_text(" 1.5", 1);
      send_text("do", 1);

      sender_gaps = 1;
      random_lines(20);

      // back-pressure: receiver holds off while the sender keeps offering
      wait_drained();
      sender_gaps  = 0;
      hold_request = 1;
      random_lines(20);
      sender_gaps = 1;

      // paren depth overflow
      gaps_now = 1;
      for (int i = 0; i <= cst_pkg::MAX_DEPTH; i++) send_beat("(", 0);
      send_beat(")", 1);

      random_lines(10);
      wait_drained();
      random_lines(5);

      quiet = 1;
      random_lines(12);

      req_valid <= 0;
      guard = 0;
      while (sb.pending() != 0 && guard < 20000) begin
         @(posedge clock);
         guard++;
      end
      repeat (16) @(posedge clock);
      if (sb.pending() != 0) begin
         sb.errors++;
         $display("%0d expected rsp beats never arrived", sb.pending());
      end
      if (sb.errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

### sim.f
hdl/cst_pkg.sv
hdl/cst_front.sv
hdl/cst_queue.sv
hdl/cst_back.sv
hdl/char_stream_tokenizer.sv
sim/char_stream_tokenizer_tb.sv
